// ===== hdl/mpq_pkg.sv =====
package mpq_pkg;

	localparam int NUM_SLOTS  = 64;
	localparam int NUM_LEVELS = 6;
	localparam int PID_BITS   = 16;

	localparam int OP_W    = 3;
	localparam int SLOT_W  = 6;
	localparam int LEVEL_W = 3;
	localparam int PORT_PID_W = 16;
	localparam int STATUS_W = 2;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	typedef enum logic [OP_W-1:0] {
		OP_ENQUEUE = 3'd0,
		OP_DEQUEUE = 3'd1,
		OP_REMOVE  = 3'd2,
		OP_SELECT  = 3'd3,
		OP_FIND    = 3'd4
	} op_t;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NONE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic                valid;
		logic [SLOT_W-1:0]   slot;
		logic [LEVEL_W-1:0]  level;
		logic [PID_BITS-1:0] pid;
	} entry_t;

	typedef struct packed {
		logic take_next;
		logic load;
	} cell_ctl_t;

endpackage

// ===== hdl/multilevel_priority_ready_queue_top.sv =====
// multilevel priority ready queue
// command channel: operation, entry_slot, level and pid are taken when start is
// high and busy is low. one result beat follows: result_slot, result_pid and
// status are valid for the single cycle in which done is high.
// storage is a row of NUM_SLOTS cells holding queued slots packed in enqueue
// order, so each level's fifo order is the order along the row.
// every valid command rotates the row one full turn past a compare unit on
// cell 0, then the finish state applies the change (append at the
// fill point, or close the gap of a dequeued/removed entry) and shows the
// result; a rejected command skips the rotation and goes straight to the
// finish state. one command at a time; busy is low again in
// the done cycle, so the next start may coincide with done.
// reset empties every queue (cell valid bits and fill count cleared at once).
// the receiver cannot stall: done is a one-cycle strobe and must be caught.
module multilevel_priority_ready_queue_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [mpq_pkg::OP_W-1:0]           operation,
	input  logic [mpq_pkg::SLOT_W-1:0]         entry_slot,
	input  logic [mpq_pkg::LEVEL_W-1:0]        level,
	input  logic [mpq_pkg::PORT_PID_W-1:0]     pid,
	output logic                               done,
	output logic [mpq_pkg::SLOT_W-1:0]         result_slot,
	output logic [mpq_pkg::PORT_PID_W-1:0]     result_pid,
	output logic [mpq_pkg::STATUS_W-1:0]       status
);
	import mpq_pkg::*;

	state_t state_q, state_d;

	logic [OP_W-1:0]     op_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [PID_BITS-1:0] pid_q;
	logic                bad_q;
	logic [IDX_W-1:0]    step_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                found_q;
	logic [IDX_W-1:0]    idx_q;
	logic [SLOT_W-1:0]   best_slot_q;
	logic [LEVEL_W-1:0]  best_level_q;
	logic [PID_BITS-1:0] best_pid_q;

	logic                done_q;
	logic [SLOT_W-1:0]   rslot_q;
	logic [PORT_PID_W-1:0] rpid_q;
	logic [STATUS_W-1:0] status_q;

	entry_t    cells [NUM_SLOTS];
	entry_t    nbrs  [NUM_SLOTS];
	cell_ctl_t ctls  [NUM_SLOTS];
	entry_t    new_entry;

	logic accept, bad_in, level_ok, slot_ok;
	logic rotate, do_load, do_shift, last_step;
	logic match, take;
	logic [STATUS_W-1:0] stat_d;
	entry_t head;

	assign accept   = start && !busy;
	assign level_ok = (level >= LEVEL_W'(1)) && (32'(level) <= NUM_LEVELS);
	assign slot_ok  = 32'(entry_slot) < NUM_SLOTS;

	always_comb begin
		unique case (operation)
			OP_ENQUEUE: bad_in = !level_ok || !slot_ok;
			OP_DEQUEUE: bad_in = !level_ok;
			OP_REMOVE:  bad_in = !slot_ok;
			OP_SELECT:  bad_in = !level_ok;
			OP_FIND:    bad_in = 1'b0;
			default:    bad_in = 1'b1;
		endcase
	end

	assign last_step = step_q == IDX_W'(NUM_SLOTS - 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (accept) state_d = bad_in ? S_FINISH : S_SCAN;
			S_SCAN:   if (last_step) state_d = S_FINISH;
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy     = state_q != S_IDLE;
		rotate   = state_q == S_SCAN;
		do_load  = 1'b0;
		do_shift = 1'b0;
		if (state_q == S_FINISH && !bad_q) begin
			if (op_q == OP_ENQUEUE && !found_q) do_load = 1'b1;
			if ((op_q == OP_DEQUEUE || op_q == OP_REMOVE) && found_q) do_shift = 1'b1;
		end
	end

	// compare unit on cell 0
	assign head = cells[0];
	always_comb begin
		unique case (op_q)
			OP_ENQUEUE, OP_REMOVE: match = head.slot == slot_q;
			OP_DEQUEUE:            match = head.level == level_q;
			OP_SELECT:             match = head.level >= level_q;
			OP_FIND:               match = head.pid == pid_q;
			default:               match = 1'b0;
		endcase
	end
	// strict compare keeps the earliest entry of the best level
	assign take = rotate && head.valid && match && (!found_q || head.level < best_level_q);

	assign new_entry.valid = 1'b1;
	assign new_entry.slot  = slot_q;
	assign new_entry.level = level_q;
	assign new_entry.pid   = pid_q;

	for (genvar j = 0; j < NUM_SLOTS; j++) begin : g_cell
		if (j < NUM_SLOTS - 1) begin : g_mid
			assign nbrs[j] = cells[j+1];
		end else begin : g_end
			// wrap for rotation, empty entry fills in when closing a gap
			always_comb begin
				nbrs[j] = cells[0];
				if (!rotate) nbrs[j].valid = 1'b0;
			end
		end
		assign ctls[j].take_next = rotate || (do_shift && IDX_W'(j) >= idx_q);
		assign ctls[j].load      = do_load && (CNT_W'(j) == cnt_q);

		mpq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctls[j]),
			.nbr       (nbrs[j]),
			.new_entry (new_entry),
			.cur       (cells[j])
		);
	end

	always_comb begin
		if (bad_q || (op_q == OP_ENQUEUE && found_q)) stat_d = STAT_BAD;
		else if (op_q == OP_ENQUEUE || found_q)        stat_d = STAT_OK;
		else                                           stat_d = STAT_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == S_FINISH;
			if (do_load) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_shift) cnt_q <= cnt_q - CNT_W'(1);
			if (accept) begin
				found_q <= 1'b0;
				step_q  <= '0;
			end else if (rotate) begin
				step_q <= step_q + IDX_W'(1);
				if (take) found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			slot_q  <= entry_slot;
			level_q <= level;
			pid_q   <= pid[PID_BITS-1:0];
			bad_q   <= bad_in;
		end
		if (take) begin
			idx_q        <= step_q;
			best_slot_q  <= head.slot;
			best_level_q <= head.level;
			best_pid_q   <= head.pid;
		end
		if (state_q == S_FINISH) begin
			status_q <= stat_d;
			if (stat_d == STAT_OK && op_q != OP_ENQUEUE) begin
				rslot_q <= best_slot_q;
				rpid_q  <= PORT_PID_W'(best_pid_q);
			end else begin
				rslot_q <= '0;
				rpid_q  <= '0;
			end
		end
	end

	assign done        = done_q;
	assign result_slot = rslot_q;
	assign result_pid  = rpid_q;
	assign status      = status_q;

endmodule

// ===== hdl/mpq_cell.sv =====
module mpq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mpq_pkg::cell_ctl_t ctl,
	input  mpq_pkg::entry_t   nbr,
	input  mpq_pkg::entry_t   new_entry,
	output mpq_pkg::entry_t   cur
);
	import mpq_pkg::*;

	logic                valid_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [PID_BITS-1:0] pid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= new_entry.valid;
		end else if (ctl.take_next) begin
			valid_q <= nbr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			slot_q  <= new_entry.slot;
			level_q <= new_entry.level;
			pid_q   <= new_entry.pid;
		end else if (ctl.take_next) begin
			slot_q  <= nbr.slot;
			level_q <= nbr.level;
			pid_q   <= nbr.pid;
		end
	end

	assign cur.valid = valid_q;
	assign cur.slot  = slot_q;
	assign cur.level = level_q;
	assign cur.pid   = pid_q;

endmodule

// ===== dv/mpq_checker.sv =====
`timescale 1ns / 100ps

module mpq_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  operation,
	input  logic [5:0]  entry_slot,
	input  logic [2:0]  level,
	input  logic [15:0] pid,
	input  logic        done,
	input  logic [5:0]  result_slot,
	input  logic [15:0] result_pid,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending,
	output int          beats_in,
	output int          ok_count
);
	import mpq_pkg::*;

	typedef struct packed {
		logic [5:0]  slot;
		logic [15:0] pid;
		logic [1:0]  stat;
	} answer_t;

	// each level is kept as a plain fifo of slots
	logic [5:0]  lvl_q[NUM_LEVELS][$];
	logic [15:0] slot_pid[NUM_SLOTS];
	logic [2:0]  slot_lvl[NUM_SLOTS];
	logic        slot_on[NUM_SLOTS];
	answer_t     answers_due[$];

	function automatic answer_t queue_step(logic [2:0] op, logic [5:0] s, logic [2:0] lv,
		logic [15:0] p);
		answer_t a;
		int li;
		a = '{slot: '0, pid: '0, stat: STAT_BAD};
		case (op)
			OP_ENQUEUE: if (lv >= 1 && lv <= NUM_LEVELS && !slot_on[s]) begin
				slot_on[s] = 1'b1;
				slot_pid[s] = p;
				slot_lvl[s] = lv;
				lvl_q[lv-1].push_back(s);
				a.stat = STAT_OK;
			end
			OP_DEQUEUE: if (lv >= 1 && lv <= NUM_LEVELS) begin
				if (lvl_q[lv-1].size() == 0) a.stat = STAT_NONE;
				else begin
					a.slot = lvl_q[lv-1].pop_front();
					slot_on[a.slot] = 1'b0;
					a.pid = slot_pid[a.slot];
					a.stat = STAT_OK;
				end
			end
			OP_REMOVE: begin
				a.stat = STAT_NONE;
				if (slot_on[s]) begin
					li = slot_lvl[s] - 1;
					for (int k = 0; k < lvl_q[li].size(); k++)
						if (lvl_q[li][k] == s) begin
							lvl_q[li].delete(k);
							break;
						end
					slot_on[s] = 1'b0;
					a = '{slot: s, pid: slot_pid[s], stat: STAT_OK};
				end
			end
			OP_SELECT: if (lv >= 1 && lv <= NUM_LEVELS) begin
				a.stat = STAT_NONE;
				for (li = lv - 1; li < NUM_LEVELS; li++)
					if (lvl_q[li].size() != 0) begin
						a.slot = lvl_q[li][0];
						a.pid = slot_pid[a.slot];
						a.stat = STAT_OK;
						break;
					end
			end
			OP_FIND: begin
				a.stat = STAT_NONE;
				for (li = 0; li < NUM_LEVELS && a.stat != STAT_OK; li++)
					for (int k = 0; k < lvl_q[li].size(); k++)
						if (slot_pid[lvl_q[li][k]] == p) begin
							a = '{slot: lvl_q[li][k], pid: p, stat: STAT_OK};
							break;
						end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		beats_in = 0;
		ok_count = 0;
		pending = 0;
		foreach (slot_on[i]) slot_on[i] = 1'b0;
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (done) begin
				if (answers_due.size() == 0)
					report_mismatch("result beat with nothing outstanding");
				else begin
					want = answers_due.pop_front();
					if (result_slot !== want.slot)
						report_mismatch($sformatf("slot %0d want %0d", result_slot, want.slot));
					if (result_pid !== want.pid)
						report_mismatch($sformatf("pid %0h want %0h", result_pid, want.pid));
					if (status !== want.stat)
						report_mismatch($sformatf("status %0d want %0d", status, want.stat));
					if (want.stat == STAT_OK) ok_count++;
				end
			end
			if (start && !busy) begin
				answers_due.push_back(queue_step(operation, entry_slot, level, pid));
				beats_in++;
			end
		end
		pending = answers_due.size();
	end
endmodule

// ===== dv/multilevel_priority_ready_queue_top_test.sv =====
`timescale 1ns / 100ps

module multilevel_priority_ready_queue_top_test;
	import mpq_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  operation;
	logic [5:0]  entry_slot;
	logic [2:0]  level;
	logic [15:0] pid;
	logic        done;
	logic [5:0]  result_slot;
	logic [15:0] result_pid;
	logic [1:0]  status;
	int          fail_count, pending, beats_in, ok_count;
	int          idle_pct;
	int          quiet_cycles;

	multilevel_priority_ready_queue_top dut (.*);

	mpq_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles with no accepted beat on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("no progress for %0d cycles", quiet_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// start drops only while idling, so it never gets two updates in one step
	task automatic send_cmd(logic [2:0] op, logic [5:0] s, logic [2:0] lv, logic [15:0] p);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		entry_slot <= s;
		level <= lv;
		pid <= p;
		do @(posedge clk); while (busy);
	endtask

	// mostly well-formed traffic: small pid pool so find hits, slots reused
	task automatic random_cmd();
		int r;
		logic [15:0] p;
		r = $urandom_range(99);
		p = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
		if (r < 35)
			send_cmd(OP_ENQUEUE, 6'($urandom), 3'($urandom_range(1, 6)), p);
		else if (r < 50) send_cmd(OP_DEQUEUE, '0, 3'($urandom_range(1, 6)), p);
		else if (r < 65) send_cmd(OP_REMOVE, 6'($urandom), 3'($urandom), p);
		else if (r < 77) send_cmd(OP_SELECT, '0, 3'($urandom_range(1, 6)), p);
		else if (r < 90) send_cmd(OP_FIND, 6'($urandom), 3'($urandom), p);
		else send_cmd(3'($urandom), 6'($urandom), 3'($urandom), 16'($urandom));
	endtask

	initial begin
		int pct[4];
		pct = '{0, 81, 0, 30};
		arst_n = 1'b0;
		start = 1'b0;
		operation = '0;
		entry_slot = '0;
		level = '0;
		pid = '0;
		idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queues, bad levels, unknown codes, extremes
		send_cmd(OP_DEQUEUE, 6'd0, 3'd1, 16'h0000);
		send_cmd(OP_SELECT, 6'd0, 3'd1, 16'h0000);
		send_cmd(OP_FIND, 6'd0, 3'd0, 16'hffff);
		send_cmd(OP_REMOVE, 6'd63, 3'd0, 16'h0000);
		send_cmd(OP_ENQUEUE, 6'd0, 3'd0, 16'h0001);
		send_cmd(OP_ENQUEUE, 6'd0, 3'd7, 16'h0001);
		send_cmd(OP_DEQUEUE, 6'd0, 3'd0, 16'h0000);
		send_cmd(OP_SELECT, 6'd0, 3'd7, 16'h0000);
		send_cmd(OP_ENQUEUE, 6'd63, 3'd6, 16'hffff);
		send_cmd(OP_ENQUEUE, 6'd0, 3'd1, 16'h0000);
		send_cmd(OP_ENQUEUE, 6'd42, 3'd1, 16'h5555);
		send_cmd(OP_ENQUEUE, 6'd21, 3'd1, 16'haaaa);
		send_cmd(OP_ENQUEUE, 6'd63, 3'd3, 16'h1234);
		send_cmd(OP_SELECT, 6'd0, 3'd2, 16'h0000);
		send_cmd(OP_FIND, 6'd0, 3'd0, 16'haaaa);
		send_cmd(OP_FIND, 6'd0, 3'd0, 16'h7777);
		send_cmd(OP_REMOVE, 6'd42, 3'd0, 16'h0000);
		send_cmd(OP_REMOVE, 6'd42, 3'd0, 16'h0000);
		send_cmd(OP_REMOVE, 6'd21, 3'd0, 16'h0000);
		send_cmd(3'd5, 6'd1, 3'd1, 16'h0001);
		send_cmd(3'd6, 6'd2, 3'd2, 16'h0002);
		send_cmd(3'd7, 6'd3, 3'd3, 16'h0003);
		send_cmd(OP_DEQUEUE, 6'd0, 3'd1, 16'h0000);
		send_cmd(OP_DEQUEUE, 6'd0, 3'd6, 16'h0000);
		send_cmd(OP_SELECT, 6'd0, 3'd1, 16'h0000);

		foreach (pct[ph]) begin
			idle_pct = pct[ph];
			repeat (480) random_cmd();
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("%0d commands sent, %0d answered ok, idle phases 0/81/0/30 percent",
			beats_in, ok_count);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/mpq_pkg.sv
hdl/mpq_cell.sv
hdl/multilevel_priority_ready_queue_top.sv
dv/mpq_checker.sv
dv/multilevel_priority_ready_queue_top_test.sv
